@@ hw/rtl/ycc_pkg.sv @@
// Package with shared types and constants for the YCbCr 4:2:2 to RGB888 converter.
`timescale 1ns / 1ps
`default_nettype none

package ycc_pkg;

   localparam int REG_BITS  = 60;
   localparam int INDEX_BITS = 2;
   localparam int CHAN_BITS = 8;
   localparam int CHAN_MAX  = 255;

   typedef logic signed [8:0] sample_type;

   localparam sample_type LUMA_OFFSET   = 9'sd16;
   localparam sample_type CHROMA_OFFSET = 9'sd128;

   localparam logic [INDEX_BITS-1:0] RED_ROW_IDX   = 2'd0;
   localparam logic [INDEX_BITS-1:0] GREEN_ROW_IDX = 2'd1;
   localparam logic [INDEX_BITS-1:0] BLUE_ROW_IDX  = 2'd2;

   typedef logic [CHAN_BITS-1:0] chan_type;
   typedef chan_type [2:0] rgb_type;
   typedef rgb_type [1:0] pixel_pair_type;

   typedef struct packed {
      logic s1_load;
      logic s2_load;
   } lane_ctl_type;

endpackage

`default_nettype wire

@@ hw/rtl/ycc_if.sv @@
// Handshake interfaces for the converter's request and response channels.
`timescale 1ns / 1ps
`default_nettype none

interface ycc_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] luma_first;
   logic [7:0] chroma_red;
   logic [7:0] luma_second;
   logic [7:0] chroma_blue;
   logic       frame_end_in;

   modport source (output valid, output luma_first, output chroma_red,
                   output luma_second, output chroma_blue, output frame_end_in,
                   input ready);
   modport sink (input valid, input luma_first, input chroma_red,
                 input luma_second, input chroma_blue, input frame_end_in,
                 output ready);
endinterface

interface ycc_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] red_first;
   logic [7:0] green_first;
   logic [7:0] blue_first;
   logic [7:0] red_second;
   logic [7:0] green_second;
   logic [7:0] blue_second;
   logic       frame_end_out;

   modport source (output valid, output red_first, output green_first,
                   output blue_first, output red_second, output green_second,
                   output blue_second, output frame_end_out, input ready);
   modport sink (input valid, input red_first, input green_first,
                 input blue_first, input red_second, input green_second,
                 input blue_second, input frame_end_out, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/ycbcr422_to_rgb888_matrix.sv @@
// Top level of the YCbCr 4:2:2 to RGB888 converter with a programmable matrix.
`timescale 1ns / 1ps
`default_nettype none

// Converts one 4:2:2 group (Y0, Cr, Y1, Cb) per clock, unless stalled, into two RGB888 pixels.
// Six lanes, one per pixel and color, each multiply the offset-removed samples
// by one matrix row, then sum, drop FRAC_BITS fraction bits and clamp to 0..255.
// The block accepts one transaction every clock while the output is not stalled;
// each one passes through the lane multiplier stage, the sum and clamp stage,
// and the output register. Each coefficient register packs three signed
// COEF_BITS-bit coefficients: Y in the low bits, then Cr, then Cb; bits beyond
// bit 59 read as zero. Write the coefficient registers only while the block is
// idle; writes to index 3 are ignored.
module ycbcr422_to_rgb888_matrix #(
   parameter int COEF_BITS = 20,
   parameter int FRAC_BITS = 16
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             csr_write_en,
   input  wire logic [ycc_pkg::INDEX_BITS-1:0]   csr_index,
   input  wire logic [ycc_pkg::REG_BITS-1:0]     csr_data,
   ycc_req_if.sink                               req_chan,
   ycc_rsp_if.source                             rsp_chan
);
   import ycc_pkg::*;

   localparam int ROW_W = (3 * COEF_BITS > REG_BITS) ? 3 * COEF_BITS : REG_BITS;

   logic [REG_BITS-1:0] row_ff [3];
   logic [ROW_W-1:0]    row_pad [3];

   logic       s1_valid_ff, s1_valid_in;
   logic       s2_valid_ff, s2_valid_in;
   logic       fe_s1_ff;
   logic       fe_s2_ff;
   logic       s1_adv;
   logic       s2_adv;
   logic       out_room;
   lane_ctl_type lane_ctl;

   sample_type luma_s [2];
   sample_type cr_s;
   sample_type cb_s;
   pixel_pair_type chans;

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff[0] <= '0;
         row_ff[1] <= '0;
         row_ff[2] <= '0;
      end else if (csr_write_en) begin
         case (csr_index)
            RED_ROW_IDX: begin
               row_ff[0] <= csr_data;
            end
            GREEN_ROW_IDX: begin
               row_ff[1] <= csr_data;
            end
            BLUE_ROW_IDX: begin
               row_ff[2] <= csr_data;
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      for (int r = 0; r < 3; r++) begin
         row_pad[r] = ROW_W'(row_ff[r]);
      end
   end

   assign s2_adv         = !s2_valid_ff || out_room;
   assign s1_adv         = !s1_valid_ff || s2_adv;
   assign req_chan.ready = s1_adv;
   assign s1_valid_in    = s1_adv ? req_chan.valid : s1_valid_ff;
   assign s2_valid_in    = s2_adv ? s1_valid_ff : s2_valid_ff;

   assign lane_ctl.s1_load = req_chan.valid && s1_adv;
   assign lane_ctl.s2_load = s1_valid_ff && s2_adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (lane_ctl.s1_load) begin
         fe_s1_ff <= req_chan.frame_end_in;
      end
      if (lane_ctl.s2_load) begin
         fe_s2_ff <= fe_s1_ff;
      end
   end

   always_comb begin
      luma_s[0] = sample_type'({1'b0, req_chan.luma_first}) - LUMA_OFFSET;
      luma_s[1] = sample_type'({1'b0, req_chan.luma_second}) - LUMA_OFFSET;
      cr_s      = sample_type'({1'b0, req_chan.chroma_red}) - CHROMA_OFFSET;
      cb_s      = sample_type'({1'b0, req_chan.chroma_blue}) - CHROMA_OFFSET;
   end

   for (genvar p = 0; p < 2; p++) begin : g_pixel
      for (genvar c = 0; c < 3; c++) begin : g_color
         ycc_lane #(
            .COEF_BITS (COEF_BITS),
            .FRAC_BITS (FRAC_BITS)
         ) u_lane (
            .clock   (clock),
            .ctl     (lane_ctl),
            .luma    (luma_s[p]),
            .cr      (cr_s),
            .cb      (cb_s),
            .coef_y  ($signed(row_pad[c][0 +: COEF_BITS])),
            .coef_cr ($signed(row_pad[c][COEF_BITS +: COEF_BITS])),
            .coef_cb ($signed(row_pad[c][2 * COEF_BITS +: COEF_BITS])),
            .chan    (chans[p][c])
         );
      end
   end

   ycc_merge u_merge (
      .clock      (clock),
      .reset      (reset),
      .load_valid (s2_valid_ff),
      .chans      (chans),
      .frame_end  (fe_s2_ff),
      .room       (out_room),
      .rsp_chan   (rsp_chan)
   );

`ifndef SYNTH
   a_empty_ready: assert property (@(posedge clock) disable iff (reset)
      !s1_valid_ff |-> req_chan.ready)
      else $error("Empty first stage did not accept a transaction.");

   a_accept_fills: assert property (@(posedge clock) disable iff (reset)
      req_chan.valid && req_chan.ready |=> s1_valid_ff)
      else $error("Accepted transaction did not reach the first stage.");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      s2_valid_ff && !s2_adv |=> s2_valid_ff)
      else $error("Stalled second stage lost its transaction.");

   a_frame_end_moves: assert property (@(posedge clock) disable iff (reset)
      lane_ctl.s2_load |=> fe_s2_ff == $past(fe_s1_ff))
      else $error("Frame-end mark did not follow its transaction.");
`endif

endmodule

`default_nettype wire

@@ hw/rtl/ycc_lane.sv @@
// One color channel of one pixel: three products, then sum, scale and clamp.
`timescale 1ns / 1ps
`default_nettype none

module ycc_lane #(
   parameter int COEF_BITS = 20,
   parameter int FRAC_BITS = 16
) (
   input  wire logic                         clock,
   input  wire ycc_pkg::lane_ctl_type        ctl,
   input  wire ycc_pkg::sample_type          luma,
   input  wire ycc_pkg::sample_type          cr,
   input  wire ycc_pkg::sample_type          cb,
   input  wire logic signed [COEF_BITS-1:0]  coef_y,
   input  wire logic signed [COEF_BITS-1:0]  coef_cr,
   input  wire logic signed [COEF_BITS-1:0]  coef_cb,
   output      ycc_pkg::chan_type            chan
);
   import ycc_pkg::*;

   localparam int PROD_W = COEF_BITS + 9;
   localparam int ACC_W  = PROD_W + 2;
   localparam int EXT_W  = ACC_W + CHAN_BITS;
   localparam int Q_W    = EXT_W - FRAC_BITS;

   logic signed [PROD_W-1:0] prod_y_ff, prod_y_in;
   logic signed [PROD_W-1:0] prod_cr_ff, prod_cr_in;
   logic signed [PROD_W-1:0] prod_cb_ff, prod_cb_in;
   logic signed [ACC_W-1:0]  acc;
   logic signed [EXT_W-1:0]  acc_ext;
   logic [Q_W-1:0]           quot;
   chan_type                 chan_ff, chan_in;

   always_comb begin
      prod_y_in  = PROD_W'(luma) * PROD_W'(coef_y);
      prod_cr_in = PROD_W'(cr) * PROD_W'(coef_cr);
      prod_cb_in = PROD_W'(cb) * PROD_W'(coef_cb);
   end

   always_comb begin
      acc     = ACC_W'(prod_y_ff) + ACC_W'(prod_cr_ff) + ACC_W'(prod_cb_ff);
      acc_ext = EXT_W'(acc);
      quot    = acc_ext[EXT_W-1:FRAC_BITS];
      if (acc[ACC_W-1]) begin
         chan_in = '0;
      end else if (quot > Q_W'(CHAN_MAX)) begin
         chan_in = CHAN_BITS'(CHAN_MAX);
      end else begin
         chan_in = quot[CHAN_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.s1_load) begin
         prod_y_ff  <= prod_y_in;
         prod_cr_ff <= prod_cr_in;
         prod_cb_ff <= prod_cb_in;
      end
      if (ctl.s2_load) begin
         chan_ff <= chan_in;
      end
   end

   assign chan = chan_ff;

endmodule

`default_nettype wire

@@ hw/rtl/ycc_merge.sv @@
// Output register that gathers the six lane channels into one response transaction.
`timescale 1ns / 1ps
`default_nettype none

module ycc_merge (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    load_valid,
   input  wire ycc_pkg::pixel_pair_type chans,
   input  wire logic                    frame_end,
   output      logic                    room,
   ycc_rsp_if.source                    rsp_chan
);
   import ycc_pkg::*;

   logic           out_valid_ff, out_valid_in;
   pixel_pair_type chans_ff;
   logic           frame_end_ff;

   assign room         = !out_valid_ff || rsp_chan.ready;
   assign out_valid_in = room ? load_valid : out_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (room && load_valid) begin
         chans_ff     <= chans;
         frame_end_ff <= frame_end;
      end
   end

   assign rsp_chan.valid         = out_valid_ff;
   assign rsp_chan.red_first     = chans_ff[0][0];
   assign rsp_chan.green_first   = chans_ff[0][1];
   assign rsp_chan.blue_first    = chans_ff[0][2];
   assign rsp_chan.red_second    = chans_ff[1][0];
   assign rsp_chan.green_second  = chans_ff[1][1];
   assign rsp_chan.blue_second   = chans_ff[1][2];
   assign rsp_chan.frame_end_out = frame_end_ff;

endmodule

`default_nettype wire
